@@ hw/rtl/dsn_pkg.sv @@
// shared constants for the height map surface normal block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dsn_pkg;

   localparam int DEF_MAX_WIDTH   = 4096;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int MAX_HEIGHT      = 4096;
   localparam int DIM_BITS        = 13;
   localparam int GAIN_BITS       = 24;
   localparam int COORD_BITS      = 12;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int QUEUE_DEPTH     = 4;
   localparam int FRAC_BITS       = 16;
   localparam int NORM_BITS       = 30;
   localparam int Q15_MAX         = 32767;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_GAIN       = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_GAIN       = 2'd3;

   localparam logic [DIM_BITS-1:0]  RESET_WIDTH  = 13'd256;
   localparam logic [DIM_BITS-1:0]  RESET_HEIGHT = 13'd256;
   localparam logic [GAIN_BITS-1:0] RESET_GAIN   = 24'd65536;

endpackage

@@ hw/rtl/dsn_queue.sv @@
// small first-in first-out queue between the front and back parts
// depends on dsn_pkg
`timescale 1ns / 1ps

module dsn_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 empty
);
   import dsn_pkg::*;

   localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [AB-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AB:0]   count_ff, count_in;

   assign full     = (count_ff == (AB+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AB'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AB'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a beat");
`endif

endmodule

@@ hw/rtl/dsn_front.sv @@
// front part: takes samples, keeps the row store and neighbours, queues pixel jobs
// depends on dsn_pkg
`timescale 1ns / 1ps

module dsn_front #(
   parameter int MAX_WIDTH   = dsn_pkg::DEF_MAX_WIDTH,
   parameter int SAMPLE_BITS = dsn_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [SAMPLE_BITS-1:0]         req_elevation,
   input  logic [dsn_pkg::DIM_BITS-1:0]          cfg_width,
   input  logic [dsn_pkg::DIM_BITS-1:0]          cfg_height,
   output logic                                  job_push,
   input  logic                                  job_full,
   output logic [dsn_pkg::COORD_BITS-1:0]        job_column,
   output logic [dsn_pkg::COORD_BITS-1:0]        job_row,
   output logic signed [SAMPLE_BITS:0]           job_dx,
   output logic signed [SAMPLE_BITS:0]           job_dy,
   output logic                                  job_last
);
   import dsn_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CB = (AW + 1 > DIM_BITS) ? AW + 1 : DIM_BITS;
   localparam int SB = SAMPLE_BITS;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_EMIT = 2'b10
   } front_state_type;

   front_state_type state_ff, state_in;

   logic signed [SB-1:0] row_mem [MAX_WIDTH];
   logic signed [SB-1:0] above_ff, cur_ff, cur_in, al_ff, al_in, left_ff, left_in;
   logic [AW-1:0]         col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [1:0]            idx_ff, idx_in;

   logic [CB-1:0]       w_ext, w_clamp, w_last;
   logic [DIM_BITS-1:0] h_clamp, h_last;
   logic                last_col, last_row, base;
   logic [3:0]          en;
   logic                cur_en, later, advance, finish, accept;
   logic signed [SB:0]  d_al_above, d_al_left, d_left_cur, d_above_cur;
   logic [COORD_BITS-1:0] col_c, col_m1;

   assign accept   = req_push && !req_full;
   assign req_full = (state_ff != F_IDLE);

   always_comb begin
      w_ext = CB'(cfg_width);
      if (w_ext < CB'(2)) begin
         w_clamp = CB'(2);
      end else if (w_ext > CB'(MAX_WIDTH)) begin
         w_clamp = CB'(MAX_WIDTH);
      end else begin
         w_clamp = w_ext;
      end
      w_last = w_clamp - 1'b1;
      if (cfg_height < DIM_BITS'(2)) begin
         h_clamp = DIM_BITS'(2);
      end else if (cfg_height > DIM_BITS'(MAX_HEIGHT)) begin
         h_clamp = DIM_BITS'(MAX_HEIGHT);
      end else begin
         h_clamp = cfg_height;
      end
      h_last = h_clamp - 1'b1;
   end

   assign last_col = (CB'(col_ff) >= w_last);
   assign last_row = ({1'b0, row_ff} >= h_last);
   assign base     = (row_ff != '0) && (col_ff != '0);
   assign en       = {base && last_col && last_row, base && last_row,
                      base && last_col, base};

   always_comb begin
      case (idx_ff)
         2'd0:    later = |en[3:1];
         2'd1:    later = |en[3:2];
         2'd2:    later = en[3];
         default: later = 1'b0;
      endcase
   end

   assign cur_en  = en[idx_ff];
   assign advance = (state_ff == F_EMIT) && (!cur_en || !job_full);
   assign finish  = advance && (idx_ff == 2'd3);
   assign job_push = (state_ff == F_EMIT) && cur_en && !job_full;
   assign job_last = !later;

   assign d_al_above  = {al_ff[SB-1], al_ff} - {above_ff[SB-1], above_ff};
   assign d_al_left   = {al_ff[SB-1], al_ff} - {left_ff[SB-1], left_ff};
   assign d_left_cur  = {left_ff[SB-1], left_ff} - {cur_ff[SB-1], cur_ff};
   assign d_above_cur = {above_ff[SB-1], above_ff} - {cur_ff[SB-1], cur_ff};

   assign col_c  = COORD_BITS'(col_ff);
   assign col_m1 = col_c - 1'b1;

   always_comb begin
      job_dx     = idx_ff[1] ? d_left_cur : d_al_above;
      job_dy     = idx_ff[0] ? d_above_cur : d_al_left;
      job_column = idx_ff[0] ? col_c : col_m1;
      job_row    = idx_ff[1] ? row_ff : row_ff - 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      al_in    = al_ff;
      left_in  = left_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               cur_in   = req_elevation;
               idx_in   = '0;
               state_in = F_EMIT;
            end
         end
         F_EMIT: begin
            if (advance) begin
               idx_in = idx_ff + 1'b1;
            end
            if (finish) begin
               al_in    = above_ff;
               left_in  = cur_ff;
               state_in = F_IDLE;
               if (last_col) begin
                  col_in = '0;
                  row_in = last_row ? '0 : row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         al_ff    <= '0;
         left_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         al_ff    <= al_in;
         left_ff  <= left_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (accept) begin
         above_ff <= row_mem[col_ff];
      end
      if (finish) begin
         row_mem[col_ff] <= cur_ff;
      end
   end

`ifndef SYNTHESIS
   a_push_in_emit: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (state_ff == F_EMIT))
      else $error("job beat outside emit");
   a_no_job_edge: assert property (@(posedge clock) disable iff (reset)
      (job_push && ((row_ff == '0) || (col_ff == '0))) |-> 1'b0)
      else $error("job from first row or column");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      finish |=> (state_ff == F_IDLE))
      else $error("front did not return to idle");
`endif

endmodule

@@ hw/rtl/dsn_back.sv @@
// back part: scales differences, normalizes, square root and three divisions
// depends on dsn_pkg
`timescale 1ns / 1ps

module dsn_back #(
   parameter int SAMPLE_BITS = dsn_pkg::DEF_SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_empty,
   output logic                               job_pop,
   input  logic [dsn_pkg::COORD_BITS-1:0]     job_column,
   input  logic [dsn_pkg::COORD_BITS-1:0]     job_row,
   input  logic signed [SAMPLE_BITS:0]        job_dx,
   input  logic signed [SAMPLE_BITS:0]        job_dy,
   input  logic                               job_last,
   input  logic [dsn_pkg::GAIN_BITS-1:0]      cfg_x_gain,
   input  logic [dsn_pkg::GAIN_BITS-1:0]      cfg_y_gain,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [dsn_pkg::COORD_BITS-1:0]     rsp_column,
   output logic [dsn_pkg::COORD_BITS-1:0]     rsp_row_index,
   output logic signed [15:0]                 rsp_normal_x,
   output logic signed [15:0]                 rsp_normal_y,
   output logic [14:0]                        rsp_normal_z,
   output logic                               rsp_last_of_run
);
   import dsn_pkg::*;

   localparam int DW = SAMPLE_BITS + 1;
   localparam int PW = DW + GAIN_BITS;
   localparam int NB = NORM_BITS;

   typedef enum logic [6:0] {
      B_IDLE     = 7'b0000001,
      B_MUL      = 7'b0000010,
      B_NORM     = 7'b0000100,
      B_SQ       = 7'b0001000,
      B_SQRT     = 7'b0010000,
      B_DIV_INIT = 7'b0100000,
      B_DIV      = 7'b1000000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic done_ff, done_in;

   logic [COORD_BITS-1:0] col_ff, row_ff;
   logic                  last_ff, sx_ff, sy_ff;
   logic [DW-1:0]         magx_ff, magy_ff;
   logic [PW-1:0]         a_ff, b_ff, o_ff;
   logic [4:0]            cnt_ff;
   logic [61:0]           sum_ff;
   logic [62:0]           r_ff;
   logic [32:0]           rem_ff;
   logic [16:0]           low_ff, q_ff;
   logic [1:0]            dsel_ff;
   logic [14:0]           nx_ff, ny_ff, nz_ff;

   logic [DW-1:0]        mag_dx, mag_dy, mul_a;
   logic [GAIN_BITS-1:0] mul_b;
   logic [PW-1:0]        prod;
   logic                 over;
   logic [NB-1:0]        sq_in, div_mag;
   logic [59:0]          sq;
   logic [62:0]          bitv, trial;
   logic [31:0]          len;
   logic [32:0]          dvs, rem2;
   logic [47:0]          num;
   logic [16:0]          q_next;
   logic [14:0]          q_sat;
   logic                 take, fire;

   assign mag_dx = job_dx[DW-1] ? DW'(-job_dx) : DW'(job_dx);
   assign mag_dy = job_dy[DW-1] ? DW'(-job_dy) : DW'(job_dy);
   assign take   = (state_ff == B_IDLE) && !done_ff && !job_empty;
   assign job_pop = take;
   assign fire   = rsp_pop && done_ff;

   assign mul_a = cnt_ff[0] ? magy_ff : magx_ff;
   assign mul_b = cnt_ff[0] ? cfg_y_gain : cfg_x_gain;
   assign prod  = {{GAIN_BITS{1'b0}}, mul_a} * {{DW{1'b0}}, mul_b};

   assign over = (|a_ff[PW-1:NB]) || (|b_ff[PW-1:NB]) || (|o_ff[PW-1:NB]);

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_in = a_ff[NB-1:0];
         2'd1:    sq_in = b_ff[NB-1:0];
         default: sq_in = o_ff[NB-1:0];
      endcase
      case (dsel_ff)
         2'd0:    div_mag = a_ff[NB-1:0];
         2'd1:    div_mag = b_ff[NB-1:0];
         default: div_mag = o_ff[NB-1:0];
      endcase
   end
   assign sq = {{NB{1'b0}}, sq_in} * {{NB{1'b0}}, sq_in};

   assign bitv  = 63'(1) << {cnt_ff, 1'b0};
   assign trial = r_ff + bitv;

   assign len  = r_ff[31:0];
   assign dvs  = {len, 1'b0};
   assign num  = {2'b0, div_mag, {FRAC_BITS{1'b0}}} + {16'b0, len};
   assign rem2 = {rem_ff[31:0], low_ff[16]};
   assign q_next = {q_ff[15:0], (rem2 >= dvs)};
   assign q_sat  = (q_next > 17'(Q15_MAX)) ? 15'(Q15_MAX) : q_next[14:0];

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (fire) begin
               done_in = 1'b0;
            end else if (take) begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            if (cnt_ff[0]) begin
               state_in = B_NORM;
            end
         end
         B_NORM: begin
            if (!over) begin
               state_in = B_SQ;
            end
         end
         B_SQ: begin
            if (cnt_ff[1:0] == 2'd2) begin
               state_in = B_SQRT;
            end
         end
         B_SQRT: begin
            if (cnt_ff == '0) begin
               state_in = B_DIV_INIT;
            end
         end
         B_DIV_INIT: state_in = B_DIV;
         B_DIV: begin
            if (cnt_ff == '0) begin
               if (dsel_ff == 2'd2) begin
                  state_in = B_IDLE;
                  done_in  = 1'b1;
               end else begin
                  state_in = B_DIV_INIT;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            if (take) begin
               col_ff  <= job_column;
               row_ff  <= job_row;
               last_ff <= job_last;
               sx_ff   <= job_dx[DW-1];
               sy_ff   <= job_dy[DW-1];
               magx_ff <= mag_dx;
               magy_ff <= mag_dy;
               cnt_ff  <= '0;
            end
         end
         B_MUL: begin
            if (cnt_ff[0]) begin
               b_ff <= prod;
               o_ff <= PW'(1) << FRAC_BITS;
            end else begin
               a_ff <= prod;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         B_NORM: begin
            if (over) begin
               a_ff <= a_ff >> 1;
               b_ff <= b_ff >> 1;
               o_ff <= o_ff >> 1;
            end else begin
               cnt_ff <= '0;
               sum_ff <= '0;
            end
         end
         B_SQ: begin
            sum_ff <= sum_ff + 62'(sq);
            if (cnt_ff[1:0] == 2'd2) begin
               cnt_ff <= 5'd30;
               r_ff   <= '0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         B_SQRT: begin
            if ({1'b0, sum_ff} >= trial) begin
               sum_ff <= sum_ff - trial[61:0];
               r_ff   <= (r_ff >> 1) + bitv;
            end else begin
               r_ff <= r_ff >> 1;
            end
            cnt_ff  <= cnt_ff - 1'b1;
            dsel_ff <= '0;
         end
         B_DIV_INIT: begin
            rem_ff <= {2'b0, num[47:17]};
            low_ff <= num[16:0];
            q_ff   <= '0;
            cnt_ff <= 5'd16;
         end
         B_DIV: begin
            rem_ff <= (rem2 >= dvs) ? rem2 - dvs : rem2;
            low_ff <= {low_ff[15:0], 1'b0};
            q_ff   <= q_next;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               case (dsel_ff)
                  2'd0:    nx_ff <= q_sat;
                  2'd1:    ny_ff <= q_sat;
                  default: nz_ff <= q_sat;
               endcase
               dsel_ff <= dsel_ff + 1'b1;
            end
         end
         default: cnt_ff <= '0;
      endcase
   end

   assign rsp_empty       = !done_ff;
   assign rsp_column      = col_ff;
   assign rsp_row_index   = row_ff;
   assign rsp_normal_x    = sx_ff ? -$signed({1'b0, nx_ff}) : $signed({1'b0, nx_ff});
   assign rsp_normal_y    = sy_ff ? -$signed({1'b0, ny_ff}) : $signed({1'b0, ny_ff});
   assign rsp_normal_z    = nz_ff;
   assign rsp_last_of_run = last_ff;

`ifndef SYNTHESIS
   a_hold_while_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == B_IDLE))
      else $error("back busy while result waits");
   a_no_take_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !job_pop)
      else $error("job taken over waiting result");
   a_norm_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SQ) |-> !over)
      else $error("operands not normalized");
`endif

endmodule

@@ hw/rtl/dem_surface_normal_stream.sv @@
// Surface normals of a streamed height map, forward differences in Q1.15.
// Takes elevation samples in raster order on the req_ queue port and gives
// one normal per pixel on the rsp_ queue port; depends on dsn_pkg and modules.
// Samples are pushed while req_full is low; the front takes one sample, then
// steps through the four possible pixel jobs, putting each enabled one into a
// four-entry job queue and stalling while it is full; req_full stays high
// until the sample is done. Results lag one row: a pixel's normal is produced
// once the sample below and to its right has arrived; the last row and column
// come out with the last samples. In the back unit each normal takes up to
// SAMPLE_BITS-6 normalizing shifts, the shared bit-serial square root (31
// steps) and three 17-step divisions. rsp_empty low marks a waiting result;
// rsp_pop takes it. If the receiver stalls, the back unit holds its result,
// the job queue fills and then req_full rises. Configuration writes (csr_we,
// csr_index, csr_wdata) take effect at once and must be done only while idle
// by the user; the block does not enforce it. Synchronous reset clears counters,
// the left and above-left neighbours, queue and registers (width and height 256,
// gains 1.0); the row store is not cleared and its first-row reads are unused.
`timescale 1ns / 1ps

module dem_surface_normal_stream #(
   parameter int MAX_WIDTH   = dsn_pkg::DEF_MAX_WIDTH,
   parameter int SAMPLE_BITS = dsn_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [SAMPLE_BITS-1:0]          req_elevation,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [dsn_pkg::COORD_BITS-1:0]         rsp_column,
   output logic [dsn_pkg::COORD_BITS-1:0]         rsp_row_index,
   output logic signed [15:0]                     rsp_normal_x,
   output logic signed [15:0]                     rsp_normal_y,
   output logic [14:0]                            rsp_normal_z,
   output logic                                   rsp_last_of_run,
   input  logic                                   csr_we,
   input  logic [dsn_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dsn_pkg::GAIN_BITS-1:0]          csr_wdata
);
   import dsn_pkg::*;

   localparam int DW = SAMPLE_BITS + 1;
   localparam int JB = 1 + 2 * COORD_BITS + 2 * DW;

   logic [DIM_BITS-1:0]  width_ff, height_ff;
   logic [GAIN_BITS-1:0] xg_ff, yg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         xg_ff     <= RESET_GAIN;
         yg_ff     <= RESET_GAIN;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_BITS-1:0];
            CSR_X_GAIN:       xg_ff     <= csr_wdata;
            CSR_Y_GAIN:       yg_ff     <= csr_wdata;
            default:          xg_ff     <= xg_ff;
         endcase
      end
   end

   logic                  fj_push, fj_full, bj_empty, bj_pop, fj_last, bj_last;
   logic [COORD_BITS-1:0] fj_col, fj_row, bj_col, bj_row;
   logic signed [DW-1:0]  fj_dx, fj_dy, bj_dx, bj_dy;
   logic [JB-1:0]         fj_data, bj_data;

   dsn_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_elevation (req_elevation),
      .cfg_width     (width_ff),
      .cfg_height    (height_ff),
      .job_push      (fj_push),
      .job_full      (fj_full),
      .job_column    (fj_col),
      .job_row       (fj_row),
      .job_dx        (fj_dx),
      .job_dy        (fj_dy),
      .job_last      (fj_last)
   );

   assign fj_data = {fj_last, fj_row, fj_col, fj_dy, fj_dx};

   dsn_queue #(
      .DATA_BITS (JB),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fj_push),
      .push_data (fj_data),
      .full      (fj_full),
      .pop       (bj_pop),
      .pop_data  (bj_data),
      .empty     (bj_empty)
   );

   assign {bj_last, bj_row, bj_col, bj_dy, bj_dx} = bj_data;

   dsn_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_empty       (bj_empty),
      .job_pop         (bj_pop),
      .job_column      (bj_col),
      .job_row         (bj_row),
      .job_dx          (bj_dx),
      .job_dy          (bj_dy),
      .job_last        (bj_last),
      .cfg_x_gain      (xg_ff),
      .cfg_y_gain      (yg_ff),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_column      (rsp_column),
      .rsp_row_index   (rsp_row_index),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y),
      .rsp_normal_z    (rsp_normal_z),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
